/* hw/rtl/odt_pkg.sv */
package odt_pkg;

    localparam int unsigned MaxWidthDef  = 128;
    localparam int unsigned MaxHeightDef = 128;

    localparam logic [7:0] FreeMark = 8'd255;
    localparam logic [7:0] DistCap  = 8'd254;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SCALE  = 2'd2,
        REG_NONE   = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SCALE,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_POP,
        ST_CENTRE,
        ST_NB_RD,
        ST_NB_WR,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [6:0]        cell_x;
        logic [6:0]        cell_y;
        logic signed [7:0] log_odds;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  distance_cells;
        logic [22:0] distance_meters_q16;
        logic        reachable;
        logic        out_of_range;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch input transaction
        logic mem_write;    // write occupancy at input cell
        logic read_req;     // read input cell
        logic scale;        // form read result
        logic clear_res;    // form run-finished result
        logic scan_start;   // reset scan and queue
        logic scan_rd;      // read scan cell
        logic scan_wr;      // rewrite / enqueue scan cell
        logic pop;          // read queue head
        logic centre_rd;    // read popped cell distance
        logic nb_rd;        // read current neighbour
        logic nb_wr;        // settle current neighbour
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic       scan_last;
        logic       queue_empty;
        logic       nb_last;
    } stat_t;

endpackage

/* hw/rtl/odt_datapath.sv */
module odt_datapath #(
    parameter int unsigned MAX_WIDTH  = odt_pkg::MaxWidthDef,
    parameter int unsigned MAX_HEIGHT = odt_pkg::MaxHeightDef
) (
    input  logic             clk,
    input  logic             rst_n,
    input  odt_pkg::in_item_t in_item,
    input  odt_pkg::ctrl_t   ctrl,
    output odt_pkg::stat_t   stat,
    input  logic [7:0]       grid_width,
    input  logic [7:0]       grid_height,
    input  logic [15:0]      meters_per_cell_q16,
    output odt_pkg::out_item_t result
);
    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT);
    localparam int unsigned AW    = XW + YW;
    // address is {y, x}, so the store spans the full power-of-two space
    localparam int unsigned CELLS = (1 << XW) * (1 << YW);
    localparam int unsigned CW    = $clog2(CELLS + 1);
    localparam int unsigned DW    = (XW > YW ? XW : YW) + 1;

    logic [7:0]  dist_mem  [CELLS];
    logic [AW-1:0] queue_mem [CELLS];

    odt_pkg::in_item_t item_reg;
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] q_rd_reg;
    logic [CW-1:0] head_reg, tail_reg;
    logic [XW-1:0] sx_reg, cx_reg;
    logic [YW-1:0] sy_reg, cy_reg;
    logic [7:0]    cd_reg;
    logic [2:0]    k_reg;
    odt_pkg::out_item_t result_reg;
    odt_pkg::out_item_t result_next;

    logic [DW-1:0] eff_w, eff_h;
    logic [8:0]    wc, hc;
    always_comb
    begin
        wc = (grid_width == 8'd0) ? 9'd1 : {1'b0, grid_width};
        hc = (grid_height == 8'd0) ? 9'd1 : {1'b0, grid_height};
        eff_w = (32'(wc) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(wc);
        eff_h = (32'(hc) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(hc);
    end

    logic in_grid;
    logic [AW-1:0] in_addr;
    assign in_grid = (DW'(item_reg.cell_x) < eff_w) && (DW'(item_reg.cell_y) < eff_h)
        && (32'(item_reg.cell_x) < MAX_WIDTH) && (32'(item_reg.cell_y) < MAX_HEIGHT);
    assign in_addr = {YW'(item_reg.cell_y), XW'(item_reg.cell_x)};

    // neighbour k offsets
    logic signed [1:0] ndx, ndy;
    always_comb
    begin
        unique case (k_reg)
            3'd0: begin ndx = 2'sd1;  ndy = 2'sd0;  end
            3'd1: begin ndx = 2'sd1;  ndy = 2'sd1;  end
            3'd2: begin ndx = 2'sd1;  ndy = -2'sd1; end
            3'd3: begin ndx = 2'sd0;  ndy = -2'sd1; end
            3'd4: begin ndx = 2'sd0;  ndy = 2'sd1;  end
            3'd5: begin ndx = -2'sd1; ndy = 2'sd1;  end
            3'd6: begin ndx = -2'sd1; ndy = -2'sd1; end
            default: begin ndx = -2'sd1; ndy = 2'sd0; end
        endcase
    end

    logic signed [DW:0] nx, ny;
    logic nb_in;
    logic [AW-1:0] nb_addr;
    assign nx = $signed({2'b0, cx_reg}) + (DW+1)'(ndx);
    assign ny = $signed({2'b0, cy_reg}) + (DW+1)'(ndy);
    assign nb_in = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, eff_w}))
        && (ny < $signed({1'b0, eff_h}));
    assign nb_addr = {ny[YW-1:0], nx[XW-1:0]};

    logic [AW-1:0] scan_addr;
    assign scan_addr = {sy_reg, sx_reg};

    logic [7:0] nd;
    assign nd = (cd_reg >= odt_pkg::DistCap) ? odt_pkg::DistCap : cd_reg + 8'd1;

    // single-port distance store: one address per cycle
    logic [AW-1:0] m_addr;
    logic          m_we;
    logic [7:0]    m_wd;
    always_comb
    begin
        m_addr = in_addr;
        m_we   = 1'b0;
        m_wd   = 8'd0;
        priority if (ctrl.mem_write)
        begin
            m_we = in_grid;
            m_wd = item_reg.log_odds[7] ? odt_pkg::FreeMark : 8'd0;
        end
        else if (ctrl.scan_rd || ctrl.scan_wr)
        begin
            m_addr = scan_addr;
            m_we   = ctrl.scan_wr && (rd_data_reg != 8'd0);
            m_wd   = odt_pkg::FreeMark;
        end
        else if (ctrl.centre_rd)
            m_addr = q_rd_reg;
        else if (ctrl.nb_rd || ctrl.nb_wr)
        begin
            m_addr = nb_addr;
            m_we   = ctrl.nb_wr && nb_in && (rd_data_reg == odt_pkg::FreeMark);
            m_wd   = nd;
        end
    end

    logic q_we;
    logic [AW-1:0] q_wd;
    assign q_we = (ctrl.scan_wr && rd_data_reg == 8'd0)
        || (ctrl.nb_wr && nb_in && rd_data_reg == odt_pkg::FreeMark);
    assign q_wd = ctrl.scan_wr ? scan_addr : nb_addr;

    always_ff @(posedge clk)
    begin
        if (m_we)
            dist_mem[m_addr] <= m_wd;
        rd_data_reg <= dist_mem[m_addr];
        if (q_we)
            queue_mem[tail_reg[AW-1:0]] <= q_wd;
        q_rd_reg <= queue_mem[head_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (ctrl.scan_start)
            begin
                head_reg <= '0;
                tail_reg <= '0;
                sx_reg   <= '0;
                sy_reg   <= '0;
            end
            else
            begin
                if (q_we)
                    tail_reg <= tail_reg + CW'(1);
                if (ctrl.pop)
                    head_reg <= head_reg + CW'(1);
                if (ctrl.scan_wr)
                begin
                    if (DW'(sx_reg) == eff_w - DW'(1))
                    begin
                        sx_reg <= '0;
                        sy_reg <= sy_reg + YW'(1);
                    end
                    else
                        sx_reg <= sx_reg + XW'(1);
                end
            end
            if (ctrl.centre_rd)
                k_reg <= '0;
            else if (ctrl.nb_wr)
                k_reg <= k_reg + 3'd1;
        end
    end

    // read result, or all zero for run finished
    logic [6:0] dist_sat;
    always_comb
    begin
        dist_sat    = rd_data_reg[7] ? 7'd127 : rd_data_reg[6:0];
        result_next = '0;
        if (!ctrl.clear_res)
        begin
            result_next.result_kind = 1'b1;
            if (!in_grid)
                result_next.out_of_range = 1'b1;
            else if (rd_data_reg != odt_pkg::FreeMark)
            begin
                result_next.reachable           = 1'b1;
                result_next.distance_cells      = dist_sat;
                result_next.distance_meters_q16 = 23'(dist_sat) * 23'(meters_per_cell_q16);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            item_reg <= in_item;
        if (ctrl.centre_rd)
        begin
            cx_reg <= q_rd_reg[XW-1:0];
            cy_reg <= q_rd_reg[AW-1:XW];
        end
        if (ctrl.nb_rd && k_reg == 3'd0)
            cd_reg <= rd_data_reg;
        if (ctrl.clear_res || ctrl.scale)
            result_reg <= result_next;
    end

    assign result = result_reg;
    assign stat.command     = item_reg.command;
    assign stat.scan_last   = (DW'(sx_reg) == eff_w - DW'(1))
        && (DW'(sy_reg) == eff_h - DW'(1));
    assign stat.queue_empty = (head_reg == tail_reg);
    assign stat.nb_last     = (k_reg == 3'd7);

endmodule

/* hw/rtl/odt_ctrl.sv */
module odt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  odt_pkg::stat_t stat,
    output odt_pkg::ctrl_t ctrl
);
    odt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= odt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            odt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next = odt_pkg::ST_READ;
                end
            end
            odt_pkg::ST_READ:
            begin
                unique case (stat.command)
                    odt_pkg::CMD_WRITE:
                    begin
                        ctrl.mem_write = 1'b1;
                        state_next = odt_pkg::ST_IDLE;
                    end
                    odt_pkg::CMD_RUN:
                    begin
                        ctrl.scan_start = 1'b1;
                        state_next = odt_pkg::ST_INIT_RD;
                    end
                    odt_pkg::CMD_READ:
                    begin
                        ctrl.read_req = 1'b1;
                        state_next = odt_pkg::ST_SCALE;
                    end
                    default: state_next = odt_pkg::ST_IDLE;
                endcase
            end
            odt_pkg::ST_SCALE:
            begin
                ctrl.scale = 1'b1;
                state_next = odt_pkg::ST_OUT;
            end
            odt_pkg::ST_INIT_RD:
            begin
                ctrl.scan_rd = 1'b1;
                state_next = odt_pkg::ST_INIT_WR;
            end
            odt_pkg::ST_INIT_WR:
            begin
                ctrl.scan_wr = 1'b1;
                state_next = stat.scan_last ? odt_pkg::ST_POP : odt_pkg::ST_INIT_RD;
            end
            odt_pkg::ST_POP:
            begin
                if (stat.queue_empty)
                    state_next = odt_pkg::ST_DONE;
                else
                begin
                    ctrl.pop = 1'b1;
                    state_next = odt_pkg::ST_CENTRE;
                end
            end
            odt_pkg::ST_CENTRE:
            begin
                ctrl.centre_rd = 1'b1;
                state_next = odt_pkg::ST_NB_RD;
            end
            odt_pkg::ST_NB_RD:
            begin
                ctrl.nb_rd = 1'b1;
                state_next = odt_pkg::ST_NB_WR;
            end
            odt_pkg::ST_NB_WR:
            begin
                ctrl.nb_wr = 1'b1;
                state_next = stat.nb_last ? odt_pkg::ST_POP : odt_pkg::ST_NB_RD;
            end
            odt_pkg::ST_DONE:
            begin
                ctrl.clear_res = 1'b1;
                state_next = odt_pkg::ST_OUT;
            end
            odt_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = odt_pkg::ST_IDLE;
            end
            default: state_next = odt_pkg::ST_IDLE;
        endcase
    end

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> !stat.queue_empty) else $error("pop from empty queue");
    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> ctrl.centre_rd) else $error("pop not followed by centre read");

endmodule

/* hw/rtl/obstacle_distance_transform.sv */
// Chessboard distance transform over an occupancy grid. Write and read
// transactions share a single-port distance store; a read result is formed
// from the registered store output. A run transaction scans the active grid
// and then works a breadth-first queue, visiting the eight neighbours of
// each popped cell. One transaction is in flight at a time; the next is
// accepted once the previous one is done and any result has been taken.
module obstacle_distance_transform #(
    parameter int unsigned MAX_WIDTH  = odt_pkg::MaxWidthDef,
    parameter int unsigned MAX_HEIGHT = odt_pkg::MaxHeightDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  odt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output odt_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    logic [7:0]  grid_width_reg, grid_height_reg;
    logic [15:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 8'd128;
            grid_height_reg <= 8'd128;
            scale_reg       <= 16'd3277;
        end
        else if (cfg_we)
        begin
            unique case (odt_pkg::reg_index_t'(cfg_index))
                odt_pkg::REG_WIDTH:  grid_width_reg  <= cfg_data[7:0];
                odt_pkg::REG_HEIGHT: grid_height_reg <= cfg_data[7:0];
                odt_pkg::REG_SCALE:  scale_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    odt_pkg::ctrl_t ctrl;
    odt_pkg::stat_t stat;

    odt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    odt_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_item             (in_data),
        .ctrl                (ctrl),
        .stat                (stat),
        .grid_width          (grid_width_reg),
        .grid_height         (grid_height_reg),
        .meters_per_cell_q16 (scale_reg),
        .result              (out_data)
    );

endmodule

/* dv/obstacle_distance_transform_tb.sv */
`timescale 1ns / 1ps

module obstacle_distance_transform_tb;

    localparam int unsigned GridMax    = 128;
    localparam int unsigned CycleLimit = 4000000;

    class dist_scoreboard;
        odt_pkg::out_item_t expected_q[$];
        int          errors;
        logic [7:0]  dist_map[GridMax*GridMax];
        bit          written[GridMax*GridMax];
        int unsigned reg_w = 128;
        int unsigned reg_h = 128;
        int unsigned reg_scale = 3277;

        function int unsigned eff_w();
            if (reg_w == 0) return 1;
            if (reg_w > GridMax) return GridMax;
            return reg_w;
        endfunction

        function int unsigned eff_h();
            if (reg_h == 0) return 1;
            if (reg_h > GridMax) return GridMax;
            return reg_h;
        endfunction

        function void set_reg(odt_pkg::reg_index_t r, logic [15:0] v);
            case (r)
                odt_pkg::REG_WIDTH:  reg_w = v[7:0];
                odt_pkg::REG_HEIGHT: reg_h = v[7:0];
                odt_pkg::REG_SCALE:  reg_scale = v;
                default: ;
            endcase
        endfunction

        // breadth-first chessboard spread from every obstacle
        function void spread();
            int          work[$];
            int          w;
            int          h;
            int          idx;
            int          cx;
            int          cy;
            int          nx;
            int          ny;
            int          n;
            logic [8:0]  nd;
            w = eff_w();
            h = eff_h();
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    idx = y * GridMax + x;
                    if (dist_map[idx] != 8'd0)
                        dist_map[idx] = odt_pkg::FreeMark;
                    else
                        work.push_back(idx);
                end
            while (work.size() != 0)
            begin
                idx = work.pop_front();
                cx = idx % GridMax;
                cy = idx / GridMax;
                for (int dx = -1; dx <= 1; dx++)
                    for (int dy = -1; dy <= 1; dy++)
                    begin
                        nx = cx + dx;
                        ny = cy + dy;
                        if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= w || ny >= h)
                            continue;
                        n = ny * GridMax + nx;
                        if (dist_map[n] == odt_pkg::FreeMark)
                        begin
                            nd = dist_map[idx] + 9'd1;
                            if (nd > odt_pkg::DistCap) nd = odt_pkg::DistCap;
                            dist_map[n] = nd[7:0];
                            work.push_back(n);
                        end
                    end
            end
        endfunction

        function void note_input(odt_pkg::in_item_t it);
            odt_pkg::out_item_t res;
            bit          in_grid;
            int          idx;
            logic [7:0]  d;
            logic [31:0] m;
            in_grid = it.cell_x < eff_w() && it.cell_y < eff_h();
            idx = it.cell_y * GridMax + it.cell_x;
            res = '0;
            case (odt_pkg::command_t'(it.command))
                odt_pkg::CMD_WRITE:
                    if (in_grid)
                    begin
                        dist_map[idx] = it.log_odds[7] ? odt_pkg::FreeMark : 8'd0;
                        written[idx] = 1'b1;
                    end
                odt_pkg::CMD_RUN:
                begin
                    spread();
                    expected_q.push_back(res);
                end
                odt_pkg::CMD_READ:
                begin
                    res.result_kind = 1'b1;
                    if (!in_grid)
                        res.out_of_range = 1'b1;
                    else if (dist_map[idx] != odt_pkg::FreeMark)
                    begin
                        d = (dist_map[idx] > 8'd127) ? 8'd127 : dist_map[idx];
                        m = d * reg_scale;
                        res.distance_cells = d[6:0];
                        res.distance_meters_q16 = m[22:0];
                        res.reachable = 1'b1;
                    end
                    expected_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check(odt_pkg::out_item_t got);
            odt_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $display("%0t: result_kind exp %0d got %0d", $time,
                         want.result_kind, got.result_kind);
                errors++;
            end
            if (got.distance_cells !== want.distance_cells)
            begin
                $display("%0t: distance_cells exp %0d got %0d", $time,
                         want.distance_cells, got.distance_cells);
                errors++;
            end
            if (got.distance_meters_q16 !== want.distance_meters_q16)
            begin
                $display("%0t: distance_meters_q16 exp %0d got %0d", $time,
                         want.distance_meters_q16, got.distance_meters_q16);
                errors++;
            end
            if (got.reachable !== want.reachable)
            begin
                $display("%0t: reachable exp %0d got %0d", $time,
                         want.reachable, got.reachable);
                errors++;
            end
            if (got.out_of_range !== want.out_of_range)
            begin
                $display("%0t: out_of_range exp %0d got %0d", $time,
                         want.out_of_range, got.out_of_range);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    odt_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_ready;
    odt_pkg::out_item_t out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    dist_scoreboard sb = new();
    int unsigned    cycle_count;
    int unsigned    burst_left;
    int unsigned    stall_mode;

    obstacle_distance_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern, re-chosen at random from three modes
    always @(posedge clk)
    begin
        if (cycle_count % 50 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (cycle_count % 9) < 4;
        endcase
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check(out_data);

    task automatic send(odt_pkg::in_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
    endtask

    task automatic put(odt_pkg::command_t c, int x, int y, int lo);
        odt_pkg::in_item_t it;
        it.command  = c;
        it.cell_x   = 7'(x);
        it.cell_y   = 7'(y);
        it.log_odds = 8'(lo);
        send(it);
    endtask

    // every expected result in, then room for a trailing write
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] s);
        odt_pkg::reg_index_t r[3];
        logic [15:0] v[3];
        r = '{odt_pkg::REG_WIDTH, odt_pkg::REG_HEIGHT, odt_pkg::REG_SCALE};
        v = '{w, h, s};
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= r[i];
            cfg_data  <= v[i];
            @(posedge clk);
            sb.set_reg(r[i], v[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // write every cell of the active grid that holds nothing yet
    task automatic fill(int obst_pct);
        for (int y = 0; y < sb.eff_h(); y++)
            for (int x = 0; x < sb.eff_w(); x++)
                if (!sb.written[y*GridMax + x])
                    put(odt_pkg::CMD_WRITE, x, y, ($urandom_range(0, 99) < obst_pct) ?
                        $urandom_range(0, 127) : -$urandom_range(1, 128));
    endtask

    task automatic random_items(int n, bit allow_run);
        int r;
        int w;
        int h;
        w = sb.eff_w();
        h = sb.eff_h();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                put(odt_pkg::CMD_WRITE, $urandom_range(0, w-1), $urandom_range(0, h-1),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : -$urandom_range(1, 128));
            else if (r < 47)
                put(odt_pkg::CMD_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom);
            else if (r < 83)
                put(odt_pkg::CMD_READ, $urandom_range(0, w-1), $urandom_range(0, h-1),
                    $urandom);
            else if (r < 91)
                put(odt_pkg::CMD_READ, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom);
            else if (r < 97 && allow_run)
                put(odt_pkg::CMD_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom);
            else
                put(odt_pkg::CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = odt_pkg::REG_WIDTH;
        cfg_data    = '0;
        out_ready   = 1'b0;
        cycle_count = 0;
        burst_left  = 0;
        stall_mode  = 0;
        sb.errors   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small grid, largest scale
        configure(4, 3, 16'hFFFF);
        fill(20);
        put(odt_pkg::CMD_WRITE, 0, 0, 127);
        put(odt_pkg::CMD_WRITE, 3, 2, -128);
        put(odt_pkg::CMD_WRITE, 1, 1, 0);
        put(odt_pkg::CMD_WRITE, 2, 2, -1);
        put(odt_pkg::CMD_WRITE, 5, 0, 0);
        put(odt_pkg::CMD_READ, 3, 2, 0);
        put(odt_pkg::CMD_RUN, 0, 0, 0);
        put(odt_pkg::CMD_READ, 0, 0, 0);
        put(odt_pkg::CMD_READ, 3, 2, 0);
        put(odt_pkg::CMD_READ, 3, 0, 0);
        put(odt_pkg::CMD_READ, 0, 2, 0);
        put(odt_pkg::CMD_READ, 4, 0, 0);
        put(odt_pkg::CMD_READ, 0, 3, 0);
        put(odt_pkg::CMD_READ, 127, 127, -1);
        put(odt_pkg::CMD_NONE, 127, 127, -1);
        // no obstacles left: everything unreachable
        put(odt_pkg::CMD_WRITE, 0, 0, -1);
        put(odt_pkg::CMD_WRITE, 1, 1, -1);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                put(odt_pkg::CMD_WRITE, x, y, -5);
        put(odt_pkg::CMD_RUN, 0, 0, 0);
        put(odt_pkg::CMD_READ, 2, 1, 0);

        // width and height zero act as one; zero scale
        configure(0, 0, 0);
        fill(50);
        random_items(60, 1);

        // oversize width acts as full width; long distances along one row
        configure(200, 1, 16'hFFFF);
        fill(0);
        put(odt_pkg::CMD_WRITE, 0, 0, 3);
        put(odt_pkg::CMD_RUN, 0, 0, 0);
        put(odt_pkg::CMD_READ, 127, 0, 0);
        put(odt_pkg::CMD_READ, 5, 0, 0);
        put(odt_pkg::CMD_READ, 0, 1, 0);
        random_items(60, 0);

        // oversize height acts as full height
        configure(1, 255, 16'hFFFF);
        fill(0);
        put(odt_pkg::CMD_WRITE, 0, 0, 3);
        put(odt_pkg::CMD_RUN, 0, 0, 0);
        put(odt_pkg::CMD_READ, 0, 127, 0);
        random_items(40, 0);

        configure(128, 1, 1);
        random_items(40, 0);

        for (int p = 0; p < 10; p++)
        begin
            configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                      16'($urandom_range(1, 65535)));
            fill(15);
            random_items(90, 1);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
